FILE: design/evad_pkg.sv
// Shared types and constants for the energy voice activity detector.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps

package evad_pkg;

  // Longest frame that is accumulated; later samples of a frame are dropped.
  localparam int MAX_FRAME_SAMPLES = 1024;

  localparam int SAMPLE_W = 16;
  // The square of a 16-bit magnitude is at most 2^30.
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int CNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W    = SQ_W + $clog2(MAX_FRAME_SAMPLES);
  // The root works on pairs of bits, so its operand is padded to an even width.
  localparam int SQ_IN_W  = SUM_W + (SUM_W % 2);
  localparam int ROOT_W   = SQ_IN_W / 2;
  localparam int ALU_W    = (ROOT_W + 3 > CNT_W + 1) ? ROOT_W + 3 : CNT_W + 1;
  localparam int STEP_W   = $clog2(SUM_W + 1);

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_LEN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT      = 2'd2;

  localparam logic [CFG_W-1:0] SPEECH_THRESHOLD_RST = 16'd500;
  localparam logic [CFG_W-1:0] TRAIL_LEN_RST        = 16'd40;
  localparam logic [CFG_W-1:0] FRAME_LIMIT_RST      = 16'd500;

  typedef enum logic [2:0] {
    VAD_SILENCE  = 3'd0,
    VAD_SPEECH   = 3'd1,
    VAD_TRAILING = 3'd2,
    VAD_DONE     = 3'd3,
    VAD_TIMEOUT  = 3'd4
  } vad_state_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ADD,
    SEQ_START,
    SEQ_CALC,
    SEQ_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    RU_IDLE,
    RU_DIV,
    RU_SQRT
  } ru_phase_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_frame;
  } vad_in_t;

  typedef struct packed {
    logic [2:0] vad_state;
    logic       frame_overlong;
  } vad_out_t;

  typedef struct packed {
    logic take;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic restart;
    logic update;
  } det_ctrl_t;

endpackage

FILE: design/evad_accum.sv
// Frame accumulator: squares each sample and sums the squares of a frame.
// Depends on evad_pkg.
`timescale 1ns / 1ps

module evad_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  evad_pkg::acc_ctrl_t                  ctrl,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
  output logic [evad_pkg::SUM_W-1:0]           square_sum,
  output logic [evad_pkg::CNT_W-1:0]           samples_in_frame,
  output logic                                 overlong_flag
);

  logic [evad_pkg::SAMPLE_W:0]     ext;
  logic [evad_pkg::SAMPLE_W:0]     mag;
  logic [2*evad_pkg::SAMPLE_W+1:0] prod;
  logic [evad_pkg::SQ_W-1:0]       sq;
  logic                            sq_add;
  logic                            room;

  assign ext  = {sample[evad_pkg::SAMPLE_W-1], sample};
  assign mag  = ext[evad_pkg::SAMPLE_W] ? (~ext + 1'b1) : ext;
  assign prod = mag * mag;
  assign room = samples_in_frame < evad_pkg::CNT_W'(evad_pkg::MAX_FRAME_SAMPLES);

  // The square is registered when the sample is taken and added in the cycle after.
  always_ff @(posedge clk) begin
    if (ctrl.take && room) begin
      sq <= prod[evad_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      square_sum       <= '0;
      samples_in_frame <= '0;
      overlong_flag    <= 1'b0;
      sq_add           <= 1'b0;
    end else begin
      if (sq_add) begin
        square_sum <= square_sum + evad_pkg::SUM_W'(sq);
      end
      sq_add <= ctrl.take && room;
      if (ctrl.take) begin
        if (room) begin
          samples_in_frame <= samples_in_frame + 1'b1;
        end else begin
          overlong_flag <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/evad_root_unit.sv
// Shared shift and subtract unit: divides the frame sum by its sample count,
// then takes the integer square root of the quotient. Depends on evad_pkg.
`timescale 1ns / 1ps

module evad_root_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [evad_pkg::SUM_W-1:0]        dividend,
  input  logic [evad_pkg::CNT_W-1:0]        divisor,
  output logic                              done,
  output logic [evad_pkg::ROOT_W-1:0]       root
);

  evad_pkg::ru_phase_t phase, phase_next;

  logic [evad_pkg::SQ_IN_W-1:0]  num;
  logic [evad_pkg::CNT_W-1:0]    den;
  logic [evad_pkg::CNT_W-1:0]    div_rem;
  logic [evad_pkg::ROOT_W:0]     sq_rem;
  logic [evad_pkg::STEP_W-1:0]   step;
  logic [evad_pkg::CNT_W:0]      div_part;
  logic [evad_pkg::ROOT_W+2:0]   sq_part;
  logic [evad_pkg::ROOT_W+1:0]   sq_trial;
  logic [evad_pkg::ALU_W-1:0]    alu_a;
  logic [evad_pkg::ALU_W-1:0]    alu_b;
  logic [evad_pkg::ALU_W:0]      diff;
  logic                          alu_ge;

  // One subtractor serves both the division and the root; its borrow decides the bit.
  assign div_part = {div_rem, num[evad_pkg::SUM_W-1]};
  assign sq_part  = {sq_rem, num[evad_pkg::SQ_IN_W-1 -: 2]};
  assign sq_trial = {root, 2'b01};
  assign alu_a    = (phase == evad_pkg::RU_SQRT) ? evad_pkg::ALU_W'(sq_part)
                                                 : evad_pkg::ALU_W'(div_part);
  assign alu_b    = (phase == evad_pkg::RU_SQRT) ? evad_pkg::ALU_W'(sq_trial)
                                                 : evad_pkg::ALU_W'(den);
  assign diff     = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = ~diff[evad_pkg::ALU_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= evad_pkg::RU_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    done       = 1'b0;
    case (phase)
      evad_pkg::RU_IDLE: begin
        if (start) begin
          phase_next = evad_pkg::RU_DIV;
        end
      end
      evad_pkg::RU_DIV: begin
        if (step == '0) begin
          phase_next = evad_pkg::RU_SQRT;
        end
      end
      evad_pkg::RU_SQRT: begin
        if (step == '0) begin
          phase_next = evad_pkg::RU_IDLE;
          done       = 1'b1;
        end
      end
      default: phase_next = evad_pkg::RU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (phase)
      evad_pkg::RU_IDLE: begin
        // The sample count is captured with the sum, since the frame is
        // cleared in the same cycle that the unit starts.
        if (start) begin
          num     <= evad_pkg::SQ_IN_W'(dividend);
          den     <= divisor;
          div_rem <= '0;
          step    <= evad_pkg::STEP_W'(evad_pkg::SUM_W - 1);
        end
      end
      evad_pkg::RU_DIV: begin
        // Quotient bits shift in at the bottom as dividend bits leave at the top.
        num     <= evad_pkg::SQ_IN_W'({num[evad_pkg::SUM_W-2:0], alu_ge});
        div_rem <= alu_ge ? diff[evad_pkg::CNT_W-1:0] : div_part[evad_pkg::CNT_W-1:0];
        if (step == '0) begin
          step   <= evad_pkg::STEP_W'(evad_pkg::ROOT_W - 1);
          root   <= '0;
          sq_rem <= '0;
        end else begin
          step <= step - 1'b1;
        end
      end
      evad_pkg::RU_SQRT: begin
        num    <= num << 2;
        root   <= {root[evad_pkg::ROOT_W-2:0], alu_ge};
        sq_rem <= alu_ge ? diff[evad_pkg::ROOT_W:0] : sq_part[evad_pkg::ROOT_W:0];
        if (step != '0) begin
          step <= step - 1'b1;
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

FILE: design/evad_detector.sv
// Detector state machine: frame count, silent run count and the five-state
// speech decision applied once per frame. Depends on evad_pkg.
`timescale 1ns / 1ps

module evad_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  evad_pkg::det_ctrl_t           ctrl,
  input  logic [evad_pkg::ROOT_W-1:0]   level,
  input  logic [evad_pkg::CFG_W-1:0]    speech_threshold,
  input  logic [evad_pkg::CFG_W-1:0]    trail_len,
  input  logic [evad_pkg::CFG_W-1:0]    frame_limit,
  output evad_pkg::vad_state_t          state_next
);

  evad_pkg::vad_state_t        state;
  logic [evad_pkg::CFG_W-1:0]  frame_counter, frame_counter_next;
  logic [evad_pkg::CFG_W-1:0]  silent_run, silent_run_next;
  logic [evad_pkg::CFG_W-1:0]  silent_inc;
  logic                        speech;

  assign speech     = level >= evad_pkg::ROOT_W'(speech_threshold);
  assign silent_inc = (silent_run != '1) ? silent_run + 1'b1 : silent_run;

  always_comb begin
    state_next         = state;
    frame_counter_next = frame_counter;
    silent_run_next    = silent_run;
    if (!(state inside {evad_pkg::VAD_DONE, evad_pkg::VAD_TIMEOUT})) begin
      frame_counter_next = (frame_counter != '1) ? frame_counter + 1'b1 : frame_counter;
      // The frame limit is checked before the level is looked at.
      if (frame_counter_next >= frame_limit) begin
        state_next = evad_pkg::VAD_TIMEOUT;
      end else begin
        case (state)
          evad_pkg::VAD_SILENCE: begin
            if (speech) begin
              state_next      = evad_pkg::VAD_SPEECH;
              silent_run_next = '0;
            end
          end
          evad_pkg::VAD_SPEECH: begin
            if (!speech) begin
              state_next      = evad_pkg::VAD_TRAILING;
              silent_run_next = evad_pkg::CFG_W'(1);
            end
          end
          evad_pkg::VAD_TRAILING: begin
            if (speech) begin
              state_next      = evad_pkg::VAD_SPEECH;
              silent_run_next = '0;
            end else begin
              silent_run_next = silent_inc;
              if (silent_inc >= trail_len) begin
                state_next = evad_pkg::VAD_DONE;
              end
            end
          end
          default: state_next = state;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      state         <= evad_pkg::VAD_SILENCE;
      frame_counter <= '0;
      silent_run    <= '0;
    end else if (ctrl.update) begin
      state         <= state_next;
      frame_counter <= frame_counter_next;
      silent_run    <= silent_run_next;
    end
  end

endmodule

FILE: design/energy_voice_activity_detector.sv
// Top level of the energy voice activity detector: sequencer, configuration
// registers and result register. Depends on evad_pkg and all evad_* modules.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_stall  sample_data  (evad_pkg::vad_in_t)
// result    out        result_valid / result_stall  result_data  (evad_pkg::vad_out_t)
// config    in         cfg_wr_en                    cfg_index, cfg_data
//
// A sample that does not end a frame, and a restart, are taken while the
// sequencer stays idle, so such transactions can follow one another in every
// cycle. A sample that ends a frame stalls the input while the sequencer walks
// its steps in order: the add step adds its square, the start step hands the
// sum to the shared subtract unit, which works out the quotient and then the
// root bit by bit, and the output step updates the detector and loads the result.
// That step waits while an earlier result is still stalled at the output.
// Reset is synchronous and active high; it restores the register defaults
// and puts the detector in silence with all counters cleared.

module energy_voice_activity_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [evad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [evad_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  evad_pkg::vad_in_t                 sample_data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output evad_pkg::vad_out_t                result_data
);

  evad_pkg::seq_state_t seq, seq_next;

  logic [evad_pkg::CFG_W-1:0]  speech_threshold;
  logic [evad_pkg::CFG_W-1:0]  trail_len;
  logic [evad_pkg::CFG_W-1:0]  frame_limit;

  evad_pkg::acc_ctrl_t         acc_ctrl;
  evad_pkg::det_ctrl_t         det_ctrl;
  logic [evad_pkg::SUM_W-1:0]  square_sum;
  logic [evad_pkg::CNT_W-1:0]  samples_in_frame;
  logic                        overlong_flag;
  logic                        overlong_hold;
  logic                        ru_start;
  logic                        ru_done;
  logic [evad_pkg::ROOT_W-1:0] level;
  evad_pkg::vad_state_t        det_next;
  logic                        out_load;

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      speech_threshold <= evad_pkg::SPEECH_THRESHOLD_RST;
      trail_len        <= evad_pkg::TRAIL_LEN_RST;
      frame_limit      <= evad_pkg::FRAME_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        evad_pkg::CFG_SPEECH_THRESHOLD: speech_threshold <= cfg_data;
        evad_pkg::CFG_TRAIL_LEN:        trail_len        <= cfg_data;
        evad_pkg::CFG_FRAME_LIMIT:      frame_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= evad_pkg::SEQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // The sequencer takes samples only when idle. A frame end walks through
  // the add, start, calculate and output steps before it returns to idle.
  always_comb begin
    seq_next         = seq;
    sample_stall     = (seq != evad_pkg::SEQ_IDLE);
    acc_ctrl.take    = 1'b0;
    acc_ctrl.clear   = 1'b0;
    det_ctrl.restart = 1'b0;
    det_ctrl.update  = 1'b0;
    ru_start         = 1'b0;
    out_load         = 1'b0;
    case (seq)
      evad_pkg::SEQ_IDLE: begin
        if (sample_valid) begin
          if (sample_data.command) begin
            det_ctrl.restart = 1'b1;
            acc_ctrl.clear   = 1'b1;
          end else begin
            acc_ctrl.take = 1'b1;
            if (sample_data.last_of_frame) begin
              seq_next = evad_pkg::SEQ_ADD;
            end
          end
        end
      end
      evad_pkg::SEQ_ADD: begin
        // The last sample's square lands in the sum during this cycle.
        seq_next = evad_pkg::SEQ_START;
      end
      evad_pkg::SEQ_START: begin
        // The subtract unit captures the sum, so the frame can be cleared now.
        ru_start       = 1'b1;
        acc_ctrl.clear = 1'b1;
        seq_next       = evad_pkg::SEQ_CALC;
      end
      evad_pkg::SEQ_CALC: begin
        if (ru_done) begin
          seq_next = evad_pkg::SEQ_OUT;
        end
      end
      evad_pkg::SEQ_OUT: begin
        if (!result_valid || !result_stall) begin
          det_ctrl.update = 1'b1;
          out_load        = 1'b1;
          seq_next        = evad_pkg::SEQ_IDLE;
        end
      end
      default: seq_next = evad_pkg::SEQ_IDLE;
    endcase
  end

  // The overlong flag is cleared with the frame, so it is held for the result.
  always_ff @(posedge clk) begin
    if (seq == evad_pkg::SEQ_START) begin
      overlong_hold <= overlong_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_data.vad_state      <= det_next;
      result_data.frame_overlong <= overlong_hold;
    end
  end

  evad_accum u_accum (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (acc_ctrl),
    .sample           (sample_data.sample),
    .square_sum       (square_sum),
    .samples_in_frame (samples_in_frame),
    .overlong_flag    (overlong_flag)
  );

  evad_root_unit u_root_unit (
    .clk      (clk),
    .rst      (rst),
    .start    (ru_start),
    .dividend (square_sum),
    .divisor  (samples_in_frame),
    .done     (ru_done),
    .root     (level)
  );

  evad_detector u_detector (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (det_ctrl),
    .level            (level),
    .speech_threshold (speech_threshold),
    .trail_len        (trail_len),
    .frame_limit      (frame_limit),
    .state_next       (det_next)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the energy voice activity detector.
// Depends on evad_pkg and energy_voice_activity_detector; reads no files.
`timescale 1ns / 1ps

module tb_top;

  // Amplitude classes used to build frames relative to the current threshold.
  typedef enum int {
    LVL_QUIET,
    LVL_LOUD,
    LVL_BORDER,
    LVL_WILD
  } level_t;

  // The scoreboard carries its own copy of the detector and its registers.
  // Every accepted sample transaction is folded into that copy, and each frame
  // end pushes the verdict that the block has to report for that frame.
  class vad_scoreboard;
    logic [15:0]          thr;
    logic [15:0]          trail;
    logic [15:0]          frame_limit;
    evad_pkg::vad_state_t det;
    logic [15:0]          frames_seen;
    logic [15:0]          silent_run;
    logic [40:0]          energy;
    logic [10:0]          sample_count;
    bit                   overlong;
    evad_pkg::vad_out_t   expected_verdicts[$];
    int                   errors;
    int                   checked;
    int                   state_hits[5];
    int                   overlong_hits;

    function new();
      thr         = evad_pkg::SPEECH_THRESHOLD_RST;
      trail       = evad_pkg::TRAIL_LEN_RST;
      frame_limit = evad_pkg::FRAME_LIMIT_RST;
      restart();
    endfunction

    function void restart();
      det          = evad_pkg::VAD_SILENCE;
      frames_seen  = '0;
      silent_run   = '0;
      energy       = '0;
      sample_count = '0;
      overlong     = 1'b0;
    endfunction

    function void set_reg(logic [evad_pkg::CFG_IDX_W-1:0] idx,
                          logic [evad_pkg::CFG_W-1:0] val);
      case (idx)
        evad_pkg::CFG_SPEECH_THRESHOLD: thr = val;
        evad_pkg::CFG_TRAIL_LEN:        trail = val;
        evad_pkg::CFG_FRAME_LIMIT:      frame_limit = val;
        default: ;
      endcase
    endfunction

    // Bit-by-bit integer square root, rounded down.
    function logic [31:0] floor_root(logic [40:0] v);
      logic [31:0] r;
      r = '0;
      for (int b = 20; b >= 0; b--) begin
        r[b] = 1'b1;
        if (64'(r) * 64'(r) > 64'(v)) r[b] = 1'b0;
      end
      return r;
    endfunction

    function void note_sample(evad_pkg::vad_in_t it);
      logic signed [16:0] sx;
      logic [16:0]        mag;
      logic [40:0]        mean;
      bit                 speech;
      evad_pkg::vad_out_t v;
      if (it.command) begin
        restart();
        return;
      end
      sx  = it.sample;
      mag = (sx < 0) ? 17'(-sx) : 17'(sx);
      if (sample_count < evad_pkg::MAX_FRAME_SAMPLES) begin
        energy       = energy + 41'(mag) * 41'(mag);
        sample_count = sample_count + 1'b1;
      end else begin
        overlong = 1'b1;
      end
      if (!it.last_of_frame) return;
      if (det != evad_pkg::VAD_DONE && det != evad_pkg::VAD_TIMEOUT) begin
        if (frames_seen != 16'hFFFF) frames_seen = frames_seen + 1'b1;
        if (frames_seen >= frame_limit) begin
          det = evad_pkg::VAD_TIMEOUT;
        end else begin
          mean   = (sample_count != 0) ? energy / 41'(sample_count) : '0;
          speech = floor_root(mean) >= 32'(thr);
          case (det)
            evad_pkg::VAD_SILENCE: begin
              if (speech) begin
                det        = evad_pkg::VAD_SPEECH;
                silent_run = '0;
              end
            end
            evad_pkg::VAD_SPEECH: begin
              if (!speech) begin
                det        = evad_pkg::VAD_TRAILING;
                silent_run = 16'd1;
              end
            end
            default: begin
              if (speech) begin
                det        = evad_pkg::VAD_SPEECH;
                silent_run = '0;
              end else begin
                if (silent_run != 16'hFFFF) silent_run = silent_run + 1'b1;
                if (silent_run >= trail) det = evad_pkg::VAD_DONE;
              end
            end
          endcase
        end
      end
      v.vad_state      = det;
      v.frame_overlong = overlong;
      expected_verdicts.push_back(v);
      energy       = '0;
      sample_count = '0;
      overlong     = 1'b0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_verdict(evad_pkg::vad_out_t got);
      evad_pkg::vad_out_t want;
      checked++;
      if (got.vad_state < 5) state_hits[got.vad_state]++;
      if (got.frame_overlong) overlong_hits++;
      if (expected_verdicts.size() == 0) begin
        complain($sformatf("unexpected result state %0d overlong %0b",
                           got.vad_state, got.frame_overlong));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.vad_state !== want.vad_state)
        complain($sformatf("frame %0d state expected %0d got %0d",
                           checked, want.vad_state, got.vad_state));
      if (got.frame_overlong !== want.frame_overlong)
        complain($sformatf("frame %0d overlong expected %0b got %0b",
                           checked, want.frame_overlong, got.frame_overlong));
    endfunction

    function void close_out();
      evad_pkg::vad_out_t want;
      while (expected_verdicts.size() != 0) begin
        want = expected_verdicts.pop_front();
        complain($sformatf("missing result state %0d overlong %0b",
                           want.vad_state, want.frame_overlong));
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [evad_pkg::CFG_IDX_W-1:0] cfg_index = evad_pkg::CFG_SPEECH_THRESHOLD;
  logic [evad_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  evad_pkg::vad_in_t              sample_data = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  evad_pkg::vad_out_t             result_data;

  vad_scoreboard sb;
  // When calm is set, neither side inserts idle cycles for the whole phase.
  bit calm = 1'b0;
  int items_sent = 0;
  int restarts_sent = 0;
  int settings_used = 1;

  energy_voice_activity_detector uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run; far beyond the slowest legal completion.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: before each transaction the receiver may raise stall for a
  // random hold, then takes the next result as soon as it shows up.
  // All reads happen right after the edge, so they see the pre-edge values.
  initial begin : result_side
    int hold;
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // Every result transaction is compared against the oldest pending verdict.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_verdict(result_data);
  end

  // Drives one input transaction after a random gap and returns at the edge
  // where it was taken. Valid is left high so that a back-to-back item does
  // not need a second assignment in the same time step.
  task automatic send_item(input evad_pkg::vad_in_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= it;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(it);
    items_sent++;
  endtask

  task automatic send_sample(input logic signed [15:0] s, input bit last);
    evad_pkg::vad_in_t it;
    it.command       = 1'b0;
    it.sample        = s;
    it.last_of_frame = last;
    send_item(it);
  endtask

  // A restart carries random sample and frame-mark bits, which must be ignored.
  task automatic send_restart();
    evad_pkg::vad_in_t it;
    it.command       = 1'b1;
    it.sample        = 16'($urandom());
    it.last_of_frame = 1'($urandom_range(0, 1));
    send_item(it);
    restarts_sent++;
  endtask

  // Picks a sample whose magnitude sits in the requested class against thr.
  // A frame built only from loud samples is guaranteed to count as speech.
  function automatic logic signed [15:0] pick_sample(level_t lvl, logic [15:0] thr);
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mag;
    logic signed [15:0] s;
    case (lvl)
      LVL_QUIET: mag = $urandom_range(0, thr / 2);
      LVL_LOUD:  mag = $urandom_range(thr, 32768);
      LVL_BORDER: begin
        lo  = (thr > 2) ? thr - 2 : 0;
        hi  = (thr + 1 > 32768) ? 32768 : thr + 1;
        mag = $urandom_range(lo, hi);
      end
      default: return 16'($urandom());
    endcase
    if (mag >= 32768) return 16'sh8000;
    s = mag[15:0];
    if ($urandom_range(0, 1)) s = -s;
    return s;
  endfunction

  task automatic send_frame(input int len, input level_t lvl);
    for (int i = 0; i < len; i++) send_sample(pick_sample(lvl, sb.thr), i == len - 1);
  endtask

  // Lowers valid, waits for every pending verdict and then lets the block
  // settle well past its end-of-frame latency, so that it is fully idle.
  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called when idle.
  task automatic program_regs(input logic [15:0] thr, input logic [15:0] trail,
                              input logic [15:0] frame_limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= evad_pkg::CFG_SPEECH_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    sb.set_reg(evad_pkg::CFG_SPEECH_THRESHOLD, thr);
    cfg_index <= evad_pkg::CFG_TRAIL_LEN;
    cfg_data  <= trail;
    @(posedge clk);
    sb.set_reg(evad_pkg::CFG_TRAIL_LEN, trail);
    cfg_index <= evad_pkg::CFG_FRAME_LIMIT;
    cfg_data  <= frame_limit;
    @(posedge clk);
    sb.set_reg(evad_pkg::CFG_FRAME_LIMIT, frame_limit);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Random traffic shaped as runs of frames of one loudness class, so the
  // detector walks through speech, trailing silence and done in earnest.
  // Occasional restarts release the sticky states; wild frames add noise.
  task automatic random_phase(input int budget);
    int     start;
    int     pick;
    int     run;
    int     len;
    level_t lvl;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 11) == 0) send_restart();
      pick = $urandom_range(0, 19);
      if (pick < 7) lvl = LVL_QUIET;
      else if (pick < 14) lvl = LVL_LOUD;
      else if (pick < 17) lvl = LVL_BORDER;
      else lvl = LVL_WILD;
      run = $urandom_range(1, 4);
      repeat (run) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) len = $urandom_range(7, 20);
        else len = $urandom_range(1, 4);
        send_frame(len, lvl);
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] thr;
    logic [15:0] trail;
    logic [15:0] frame_limit;
    int          pick;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: threshold 500, trail 40, limit 500.
    send_sample(16'sd0, 1'b1);              // silent frame keeps silence
    send_sample(16'sd32767, 1'b1);          // loudest positive: speech
    send_sample(-16'sd32768, 1'b0);         // most negative sample
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd499, 1'b0);            // level just under the threshold
    send_sample(16'sd500, 1'b1);
    send_sample(16'sd500, 1'b1);            // level exactly at the threshold
    send_sample(-16'sd499, 1'b1);
    send_restart();
    send_sample(16'sd501, 1'b0);            // samples of a frame cut by a restart
    send_restart();
    send_sample(16'sd501, 1'b0);
    send_sample(-16'sd501, 1'b0);
    send_sample(16'sd0, 1'b1);
    // One sample past the limit: the first full frame's worth is summed and
    // the last sample is dropped and marks the frame overlong.
    send_frame(evad_pkg::MAX_FRAME_SAMPLES + 1, LVL_WILD);
    send_sample(16'sd1, 1'b1);              // the overlong mark must be cleared
    drain();

    // Highest threshold, shortest trail: only full-scale negative frames count.
    program_regs(16'd32768, 16'd1, 16'd65535);
    send_sample(-16'sd32768, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);          // just below full scale: silent
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b1);              // first silent frame is never tested
    send_sample(16'sd0, 1'b1);              // second one ends the utterance
    send_sample(-16'sd32768, 1'b1);         // done holds
    send_restart();
    send_sample(-16'sd32768, 1'b1);
    drain();

    // Zero threshold and a limit of one frame: the limit wins over the level.
    program_regs(16'd0, 16'd65535, 16'd1);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);              // timeout holds
    send_restart();
    send_sample(16'sd5, 1'b1);
    drain();

    // Zero threshold with the highest limit: even an all-zero frame is speech.
    program_regs(16'd0, 16'd65535, 16'd65535);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b1);
    drain();

    // Random settings, biased toward short trails and limits that are reached.
    for (int p = 0; p < 9; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 7);
      if (pick < 2) thr = 16'($urandom_range(0, 32768));
      else if (pick < 6) thr = 16'($urandom_range(50, 3000));
      else thr = pick[0] ? 16'd0 : 16'd32768;
      pick = $urandom_range(0, 19);
      if (pick < 14) trail = 16'($urandom_range(1, 5));
      else if (pick < 17) trail = 16'($urandom_range(6, 65535));
      else trail = 16'd65535;
      pick = $urandom_range(0, 9);
      if (pick == 0) frame_limit = 16'($urandom_range(1, 7));
      else if (pick < 5) frame_limit = 16'($urandom_range(8, 60));
      else if (pick < 8) frame_limit = 16'($urandom_range(61, 65535));
      else frame_limit = 16'd65535;
      program_regs(thr, trail, frame_limit);
      random_phase(25);
      drain();
    end

    sb.close_out();
    $display("Sent %0d transactions (%0d restarts) under %0d register settings.",
             items_sent, restarts_sent, settings_used);
    $display("Checked %0d frames: silence %0d, speech %0d, trailing %0d,",
             sb.checked, sb.state_hits[0], sb.state_hits[1], sb.state_hits[2]);
    $display("  done %0d, timeout %0d, overlong %0d.",
             sb.state_hits[3], sb.state_hits[4], sb.overlong_hits);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total.", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/evad_pkg.sv
design/evad_accum.sv
design/evad_root_unit.sv
design/evad_detector.sv
design/energy_voice_activity_detector.sv
tb/tb_top.sv
